// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define AST_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define AST_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tbc_pkg.sv =====
package tbc_pkg;

  // item operation codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_BOX    = 2'd1;
  localparam logic [1:0] OP_GROUND = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MAP_ROWS = 2'd0;
  localparam logic [1:0] CFG_MAP_COLS = 2'd1;

  // ground strip: inset 4 px on each side, 2 px tall, ending at the box bottom
  localparam logic signed [4:0] GND_X_LO_OFF = 5'sd4;
  localparam logic signed [4:0] GND_X_HI_OFF = 5'sd4 - 5'sd8;
  localparam logic signed [4:0] GND_Y_LO_OFF = -5'sd2;
  localparam logic signed [4:0] NO_OFF       = 5'sd0;

  // tile span along one axis
  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic       empty;
  } span_t;

endpackage

// ===== hw/rtl/tilemap_box_collision.sv =====
// sequence: write S_WRITE, S_DONE; query S_XSPAN, S_YSPAN, S_SCAN, S_DRAIN, S_DONE
//   (scan stops at the first solid tile), empty span or no map from S_YSPAN to S_DONE, other ops straight to S_DONE
// throughput: one item at a time; a query reads one tile per cycle through the single
//   map read port, so the scan sets the item time
// reset: sequencer, output valid and map size registers clear; tile memory is not cleared
module tilemap_box_collision #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 128,
  parameter int TILE_SHIFT = 5
) (
  input  logic               clk,
  input  logic               rst,
  // item input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [5:0]         tile_row,
  input  logic [6:0]         tile_col,
  input  logic [15:0]        tile_value,
  input  logic signed [15:0] box_x,
  input  logic signed [15:0] box_y,
  input  logic [14:0]        box_w,
  input  logic [14:0]        box_h,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // one-hot sequencer
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WRITE = 7'b0000010,
    S_XSPAN = 7'b0000100,
    S_YSPAN = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // map size registers
  logic [6:0] map_rows;
  logic [7:0] map_cols;

  // captured item
  logic [1:0]         cur_op;
  logic [5:0]         cur_row;
  logic [6:0]         cur_col;
  logic [15:0]        cur_value;
  logic signed [15:0] bx;
  logic signed [15:0] by;
  logic [14:0]        bw;
  logic [14:0]        bh;

  // span and scan position
  logic [7:0] col_lo, col_hi;
  logic [7:0] row_hi;
  logic       x_empty;
  logic [7:0] col_cnt, row_cnt;
  logic       rd_pend;
  logic       res_hit;
  logic       last_tile;
  logic       slot_free;

  // shared edge unit operands
  logic               sel_y;
  logic               ground;
  logic signed [15:0] eu_base;
  logic [14:0]        eu_ext;
  logic               eu_lo_ext;
  logic signed [4:0]  eu_lo_off;
  logic signed [4:0]  eu_hi_off;
  logic [7:0]         eu_dim;
  tbc_pkg::span_t     span;

  // tile memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;
  logic          wr_in_store;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  // output register frees up when empty or when its transfer happens this cycle
  assign slot_free = !out_valid || !out_stall;
  assign last_tile = (col_cnt == col_hi) && (row_cnt == row_hi);

  // ---------------------------------------------------------------------------
  // configuration: rows come from the low 7 data bits; values beyond the store are clamped to its size
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      map_rows <= '0;
      map_cols <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tbc_pkg::CFG_MAP_ROWS: begin
          if (11'(cfg_data[6:0]) > 11'(MAX_ROWS)) map_rows <= 7'(MAX_ROWS);
          else map_rows <= cfg_data[6:0];
        end
        tbc_pkg::CFG_MAP_COLS: begin
          if (11'(cfg_data) > 11'(MAX_COLS)) map_cols <= 8'(MAX_COLS);
          else map_cols <= cfg_data;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // shared edge unit: column pass first, then row pass
  // ---------------------------------------------------------------------------
  always_comb begin
    sel_y     = (state == S_YSPAN);
    ground    = (cur_op == tbc_pkg::OP_GROUND);
    eu_base   = sel_y ? by : bx;
    eu_ext    = sel_y ? bh : bw;
    eu_dim    = sel_y ? {1'b0, map_rows} : map_cols;
    // ground strip top edge sits 2 px above the box bottom
    eu_lo_ext = ground && sel_y;
    if (!ground) begin
      eu_lo_off = tbc_pkg::NO_OFF;
      eu_hi_off = tbc_pkg::NO_OFF;
    end else if (sel_y) begin
      eu_lo_off = tbc_pkg::GND_Y_LO_OFF;
      eu_hi_off = tbc_pkg::NO_OFF;
    end else begin
      eu_lo_off = tbc_pkg::GND_X_LO_OFF;
      eu_hi_off = tbc_pkg::GND_X_HI_OFF;
    end
  end

  tbc_edge_unit #(
    .TILE_SHIFT(TILE_SHIFT)
  ) u_edge (
    .base  (eu_base),
    .ext   (eu_ext),
    .lo_ext(eu_lo_ext),
    .lo_off(eu_lo_off),
    .hi_off(eu_hi_off),
    .dim   (eu_dim),
    .span  (span)
  );

  // ---------------------------------------------------------------------------
  // tile memory: row-major, row stride of the full store width
  // ---------------------------------------------------------------------------
  assign wr_in_store = (11'(cur_row) < 11'(MAX_ROWS)) && (11'(cur_col) < 11'(MAX_COLS));
  assign mem_we      = (state == S_WRITE) && wr_in_store;
  assign mem_waddr   = AW'(int'(cur_row) * MAX_COLS + int'(cur_col));
  assign mem_raddr   = AW'(int'(row_cnt) * MAX_COLS + int'(col_cnt));

  tbc_tile_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(cur_value),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op == tbc_pkg::OP_WRITE) state_next = S_WRITE;
          else if (op inside {tbc_pkg::OP_BOX, tbc_pkg::OP_GROUND}) state_next = S_XSPAN;
          else state_next = S_DONE;
        end
      end
      S_WRITE: state_next = S_DONE;
      S_XSPAN: state_next = S_YSPAN;
      S_YSPAN: begin
        if (span.empty || x_empty) state_next = S_DONE;
        else state_next = S_SCAN;
      end
      S_SCAN: begin
        // data of the previous read is checked while the next one is issued
        if (rd_pend && (mem_rdata != 16'd0)) state_next = S_DONE;
        else if (last_tile) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cur_op    <= op;
          cur_row   <= tile_row;
          cur_col   <= tile_col;
          cur_value <= tile_value;
          bx        <= box_x;
          by        <= box_y;
          bw        <= box_w;
          bh        <= box_h;
          res_hit   <= 1'b0;
        end
      end
      S_XSPAN: begin
        col_lo  <= span.lo;
        col_hi  <= span.hi;
        x_empty <= span.empty;
      end
      S_YSPAN: begin
        row_hi  <= span.hi;
        row_cnt <= span.lo;
        col_cnt <= col_lo;
        rd_pend <= 1'b0;
      end
      S_SCAN: begin
        rd_pend <= 1'b1;
        if (rd_pend && (mem_rdata != 16'd0)) res_hit <= 1'b1;
        // walk the span row by row
        if (col_cnt == col_hi) begin
          col_cnt <= col_lo;
          row_cnt <= row_cnt + 8'd1;
        end else begin
          col_cnt <= col_cnt + 8'd1;
        end
      end
      S_DRAIN: res_hit <= (mem_rdata != 16'd0);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if ((state == S_DONE) && slot_free) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && slot_free) hit <= res_hit;
  end

endmodule

// ===== hw/rtl/tbc_edge_unit.sv =====
module tbc_edge_unit #(
  parameter int TILE_SHIFT = 5
) (
  input  logic signed [15:0] base,
  input  logic [14:0]        ext,
  input  logic               lo_ext,
  input  logic signed [4:0]  lo_off,
  input  logic signed [4:0]  hi_off,
  input  logic [7:0]         dim,
  output tbc_pkg::span_t     span
);

  localparam int SW = 18;
  localparam int QW = SW - TILE_SHIFT;
  localparam logic signed [SW-1:0] NEG_T = -(18'sd1 <<< TILE_SHIFT);

  logic signed [SW-1:0] base_s;
  logic signed [SW-1:0] ext_s;
  logic signed [SW-1:0] lo_n;
  logic signed [SW-1:0] hi_n;
  logic [QW-1:0]        lo_q;
  logic [QW-1:0]        hi_q;
  logic [7:0]           lim;
  logic [7:0]           hi_c;
  logic                 hi_far;

  always_comb begin
    base_s = {{2{base[15]}}, base};
    ext_s  = {3'b000, ext};
    lo_n   = base_s + (lo_ext ? ext_s : '0) + {{13{lo_off[4]}}, lo_off};
    hi_n   = base_s + ext_s + {{13{hi_off[4]}}, hi_off};

    // truncation toward zero: anything negative above -T lands on tile 0
    lo_q   = lo_n[SW-1] ? '0 : QW'(lo_n[SW-1:TILE_SHIFT]);
    hi_q   = hi_n[SW-1] ? '0 : QW'(hi_n[SW-1:TILE_SHIFT]);
    hi_far = (hi_n <= NEG_T);

    lim  = dim - 8'd1;
    hi_c = (hi_q > QW'(lim)) ? lim : hi_q[7:0];

    span.lo    = lo_q[7:0];
    span.hi    = hi_c;
    span.empty = hi_far || (dim == 8'd0) || (lo_q > QW'(hi_c));
  end

endmodule

// ===== hw/rtl/tbc_tile_ram.sv =====
module tbc_tile_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tbc_checker.sv =====
`include "assert_macros.svh"

module tbc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic hit,
  input logic cfg_valid,
  input logic cfg_ready
);

  // block goes busy right after taking an item
  `AST_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall, "no busy after transfer")
  // a new result only appears after an item was in work
  `AST_IMPLY(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall), "stray result")
  // configuration writes are never held off
  `AST_IMPLY(a_cfg_always_ready, clk, rst, cfg_valid, cfg_ready, "config write held off")
  // a stalled result keeps its value
  `AST_NEXT(a_result_hold, clk, rst, out_valid && out_stall, out_valid && $stable(hit), "result lost")

endmodule

bind tilemap_box_collision tbc_checker u_tbc_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .hit      (hit),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready)
);
